// ===== rtl/tof_cliff_baseline_calibrator_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef TOF_CLIFF_BASELINE_CALIBRATOR_MACROS_SVH
`define TOF_CLIFF_BASELINE_CALIBRATOR_MACROS_SVH

// Property sampled on the rising clock edge and ignored while reset is high.
`define TCBC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property sampled on every rising clock edge, reset included.
`define TCBC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/tcbc_pkg.sv =====
package tcbc_pkg;

  // Field and state widths.
  localparam int LIM_W  = 12;
  localparam int SUM_W  = 18;
  localparam int CNT_W  = 6;
  localparam int PCT_W  = 8;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 5;

  // Sample codes that the sensor uses to flag a bad reading.
  localparam logic [SUM_W-1:0] INVALID_A = SUM_W'(4);
  localparam logic [SUM_W-1:0] INVALID_B = SUM_W'(1200);

  localparam logic [SUM_W:0] CLIFF_OFFSET = (SUM_W+1)'(75);

  // Percent scaling: the product is saturated where its quotient by 100 reaches
  // 4096, which no clamp bound can exceed, then divided by 100 as a divide by 4
  // followed by an exact reciprocal multiply for 25.
  localparam int XP_W  = SUM_W + PCT_W;
  localparam int SAT_W = 19;
  localparam logic [SAT_W-1:0] SAT_LIMIT = SAT_W'(4096 * 100);
  localparam int Y_W   = SAT_W - 2;
  localparam int M25_W = 18;
  localparam logic [M25_W-1:0] RECIP25 = M25_W'(167773);
  localparam int RECIP25_SH = 22;
  localparam int QP_W  = Y_W + M25_W;
  localparam int Q_W   = 13;
  localparam int CLAMP_W = SAT_W;

  // Register map, one 32-bit word each.
  typedef enum logic [2:0] {
    REG_CLIFF_HI    = 3'd0,
    REG_CLIFF_LO    = 3'd1,
    REG_OBST_PCT    = 3'd2,
    REG_OBST_HI     = 3'd3,
    REG_OBST_LO     = 3'd4,
    REG_KNOLL_PCT   = 3'd5,
    REG_KNOLL_HI    = 3'd6,
    REG_KNOLL_LO    = 3'd7
  } reg_idx_t;

  localparam logic [LIM_W-1:0] RST_CLIFF_HI  = LIM_W'(185);
  localparam logic [LIM_W-1:0] RST_CLIFF_LO  = LIM_W'(165);
  localparam logic [PCT_W-1:0] RST_OBST_PCT  = PCT_W'(70);
  localparam logic [LIM_W-1:0] RST_OBST_HI   = LIM_W'(100);
  localparam logic [LIM_W-1:0] RST_OBST_LO   = LIM_W'(40);
  localparam logic [PCT_W-1:0] RST_KNOLL_PCT = PCT_W'(130);
  localparam logic [LIM_W-1:0] RST_KNOLL_HI  = LIM_W'(160);
  localparam logic [LIM_W-1:0] RST_KNOLL_LO  = LIM_W'(110);

  typedef struct packed {
    logic [LIM_W-1:0] cliff_hi;
    logic [LIM_W-1:0] cliff_lo;
    logic [PCT_W-1:0] obst_pct;
    logic [LIM_W-1:0] obst_hi;
    logic [LIM_W-1:0] obst_lo;
    logic [PCT_W-1:0] knoll_pct;
    logic [LIM_W-1:0] knoll_hi;
    logic [LIM_W-1:0] knoll_lo;
  } cfg_t;

  // Baseline and the three limits of one channel.
  typedef struct packed {
    logic [LIM_W-1:0] baseline;
    logic [LIM_W-1:0] cliff;
    logic [LIM_W-1:0] obstacle;
    logic [LIM_W-1:0] knoll;
  } chan_vals_t;

  // Pipeline stage load strobes for the channel datapath.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_load_t;

  // Per-request decisions made when the request is accepted.
  typedef struct packed {
    logic calibrated;
    logic just;
    logic left_rdy;
    logic right_rdy;
  } item_flags_t;

  // High bound is tested first, so with crossed bounds a value at or above the high bound gets the high one.
  function automatic logic [LIM_W-1:0] clamp_lim(input logic [CLAMP_W-1:0] v,
                                                 input logic [LIM_W-1:0] hi,
                                                 input logic [LIM_W-1:0] lo);
    logic [LIM_W-1:0] r;
    if (v >= CLAMP_W'(hi)) begin
      r = hi;
    end else if (v <= CLAMP_W'(lo)) begin
      r = lo;
    end else begin
      r = v[LIM_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/tcbc_ifaces.sv =====
// Request channel: one left and one right range sample.
interface tcbc_sample_if #(parameter int RANGE_BITS = 12) ();
  logic                  valid;
  logic                  ready;
  logic [RANGE_BITS-1:0] left_range;
  logic [RANGE_BITS-1:0] right_range;

  modport source (output valid, output left_range, output right_range, input ready);
  modport sink   (input valid, input left_range, input right_range, output ready);
endinterface

// Result channel: calibration status, baselines and limits.
interface tcbc_result_if import tcbc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             calibrated;
  logic             just_completed;
  logic [LIM_W-1:0] left_baseline;
  logic [LIM_W-1:0] right_baseline;
  logic [LIM_W-1:0] left_cliff_threshold;
  logic [LIM_W-1:0] right_cliff_threshold;
  logic [LIM_W-1:0] left_obstacle_threshold;
  logic [LIM_W-1:0] right_obstacle_threshold;
  logic [LIM_W-1:0] left_knoll_threshold;
  logic [LIM_W-1:0] right_knoll_threshold;

  modport source (output valid, output calibrated, output just_completed,
                  output left_baseline, output right_baseline,
                  output left_cliff_threshold, output right_cliff_threshold,
                  output left_obstacle_threshold, output right_obstacle_threshold,
                  output left_knoll_threshold, output right_knoll_threshold,
                  input ready);
  modport sink   (input valid, input calibrated, input just_completed,
                  input left_baseline, input right_baseline,
                  input left_cliff_threshold, input right_cliff_threshold,
                  input left_obstacle_threshold, input right_obstacle_threshold,
                  input left_knoll_threshold, input right_knoll_threshold,
                  output ready);
endinterface

// ===== rtl/tcbc_regs.sv =====
module tcbc_regs import tcbc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cliff_hi  <= RST_CLIFF_HI;
      cfg.cliff_lo  <= RST_CLIFF_LO;
      cfg.obst_pct  <= RST_OBST_PCT;
      cfg.obst_hi   <= RST_OBST_HI;
      cfg.obst_lo   <= RST_OBST_LO;
      cfg.knoll_pct <= RST_KNOLL_PCT;
      cfg.knoll_hi  <= RST_KNOLL_HI;
      cfg.knoll_lo  <= RST_KNOLL_LO;
    end else if (wr) begin
      case (idx)
        REG_CLIFF_HI:  cfg.cliff_hi  <= pwdata[LIM_W-1:0];
        REG_CLIFF_LO:  cfg.cliff_lo  <= pwdata[LIM_W-1:0];
        REG_OBST_PCT:  cfg.obst_pct  <= pwdata[PCT_W-1:0];
        REG_OBST_HI:   cfg.obst_hi   <= pwdata[LIM_W-1:0];
        REG_OBST_LO:   cfg.obst_lo   <= pwdata[LIM_W-1:0];
        REG_KNOLL_PCT: cfg.knoll_pct <= pwdata[PCT_W-1:0];
        REG_KNOLL_HI:  cfg.knoll_hi  <= pwdata[LIM_W-1:0];
        REG_KNOLL_LO:  cfg.knoll_lo  <= pwdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Read data is the zero-extended register value.
  always_comb begin
    case (idx)
      REG_CLIFF_HI:  prdata = DATA_W'(cfg.cliff_hi);
      REG_CLIFF_LO:  prdata = DATA_W'(cfg.cliff_lo);
      REG_OBST_PCT:  prdata = DATA_W'(cfg.obst_pct);
      REG_OBST_HI:   prdata = DATA_W'(cfg.obst_hi);
      REG_OBST_LO:   prdata = DATA_W'(cfg.obst_lo);
      REG_KNOLL_PCT: prdata = DATA_W'(cfg.knoll_pct);
      REG_KNOLL_HI:  prdata = DATA_W'(cfg.knoll_hi);
      REG_KNOLL_LO:  prdata = DATA_W'(cfg.knoll_lo);
      default:       prdata = '0;
    endcase
  end

endmodule

// ===== rtl/tcbc_chan.sv =====
// Baseline and limit datapath of one channel. The channel sum is frozen once
// the sample count is reached, and stage 1 takes it at acceptance. Stage 2 and
// the final clamps read cfg live; the block does not hold it stable in flight.
module tcbc_chan import tcbc_pkg::*; #(
  parameter int SAMPLE_COUNT = 50
) (
  input  logic             clk,
  input  stage_load_t      load,
  input  logic [SUM_W-1:0] sum,
  input  cfg_t             cfg,
  output chan_vals_t       vals
);

  // Exact division by the sample count: ceil(2^SH / N), then shift by SH.
  localparam int RECIP_SH = SUM_W + $clog2(SAMPLE_COUNT);
  localparam int RECIP_W  = SUM_W + 2;
  localparam int PROD_W   = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(
    ((longint'(1) << RECIP_SH) + longint'(SAMPLE_COUNT) - longint'(1)) /
    longint'(SAMPLE_COUNT));

  logic [PROD_W-1:0]  s1_prod;
  logic [SUM_W-1:0]   avg;
  logic [SUM_W:0]     cliff_full;
  logic [XP_W-1:0]    xo_full;
  logic [XP_W-1:0]    xk_full;
  logic [SAT_W-1:0]   xo_sat;
  logic [SAT_W-1:0]   xk_sat;

  logic [LIM_W-1:0]   s2_base;
  logic [LIM_W-1:0]   s2_cliff;
  logic [SAT_W-1:0]   s2_xo;
  logic [SAT_W-1:0]   s2_xk;

  logic [LIM_W-1:0]   s3_base;
  logic [LIM_W-1:0]   s3_cliff;
  logic [QP_W-1:0]    s3_po;
  logic [QP_W-1:0]    s3_pk;

  logic [Q_W-1:0]     q_obst;
  logic [Q_W-1:0]     q_knoll;

  // Stage 1: reciprocal multiply of the frozen sum.
  always_ff @(posedge clk) begin
    if (load.s1) begin
      s1_prod <= PROD_W'(sum) * PROD_W'(RECIP);
    end
  end

  // Stage 2: cliff limit and the percent products.
  assign avg        = SUM_W'(s1_prod >> RECIP_SH);
  assign cliff_full = (SUM_W+1)'(avg) + CLIFF_OFFSET;
  assign xo_full    = XP_W'(avg) * XP_W'(cfg.obst_pct);
  assign xk_full    = XP_W'(avg) * XP_W'(cfg.knoll_pct);
  assign xo_sat     = (xo_full >= XP_W'(SAT_LIMIT)) ? SAT_LIMIT : SAT_W'(xo_full);
  assign xk_sat     = (xk_full >= XP_W'(SAT_LIMIT)) ? SAT_LIMIT : SAT_W'(xk_full);

  always_ff @(posedge clk) begin
    if (load.s2) begin
      s2_base  <= avg[LIM_W-1:0];
      s2_cliff <= clamp_lim(cliff_full, cfg.cliff_hi, cfg.cliff_lo);
      s2_xo    <= xo_sat;
      s2_xk    <= xk_sat;
    end
  end

  // Stage 3: divide the saturated products by 100.
  always_ff @(posedge clk) begin
    if (load.s3) begin
      s3_base  <= s2_base;
      s3_cliff <= s2_cliff;
      s3_po    <= QP_W'(s2_xo[SAT_W-1:2]) * QP_W'(RECIP25);
      s3_pk    <= QP_W'(s2_xk[SAT_W-1:2]) * QP_W'(RECIP25);
    end
  end

  // Final clamps feed the result register.
  assign q_obst  = Q_W'(s3_po >> RECIP25_SH);
  assign q_knoll = Q_W'(s3_pk >> RECIP25_SH);

  assign vals.baseline = s3_base;
  assign vals.cliff    = s3_cliff;
  assign vals.obstacle = clamp_lim(CLAMP_W'(q_obst), cfg.obst_hi, cfg.obst_lo);
  assign vals.knoll    = clamp_lim(CLAMP_W'(q_knoll), cfg.knoll_hi, cfg.knoll_lo);

endmodule

// ===== rtl/tof_cliff_baseline_calibrator.sv =====
// Channel   Direction  Handshake             Payload
// samples   in         valid / ready         left_range, right_range
// limits    out        valid / ready         status, baselines, limits
// apb       in / out   psel, penable, pready register write and read
//
// One request can be accepted every clock while the result channel is not stalled.
// Its result goes through the three-stage limit datapath (reciprocal divide,
// percent multiply, divide by 100) and then a result register.
// Reset clears the sums, counts, calibration flag, held limits and all valids.
// Each stage moves when the next one is empty or moving, so bubbles close up.
// A stalled result still lets three more requests in before the input stalls.
module tof_cliff_baseline_calibrator import tcbc_pkg::*; #(
  parameter int SAMPLE_COUNT = 50,
  parameter int RANGE_BITS   = 12
) (
  input  logic              clk,
  input  logic              rst,
  tcbc_sample_if.sink       samples,
  tcbc_result_if.source     limits,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t             cfg;

  logic [SUM_W-1:0] left_sum;
  logic [SUM_W-1:0] right_sum;
  logic [CNT_W-1:0] left_count;
  logic [CNT_W-1:0] right_count;
  logic             done_flag;

  logic [SUM_W-1:0] lsamp;
  logic [SUM_W-1:0] rsamp;
  logic             l_ok;
  logic             r_ok;
  logic             l_full;
  logic             r_full;
  item_flags_t      flags_next;

  logic             v1;
  logic             v2;
  logic             v3;
  logic             ovalid;
  item_flags_t      s1_fl;
  item_flags_t      s2_fl;
  item_flags_t      s3_fl;
  logic             acc;
  logic             mv1;
  logic             mv2;
  logic             mv3;
  logic             free1;
  logic             free2;
  logic             free3;
  stage_load_t      load;

  chan_vals_t       vals_l;
  chan_vals_t       vals_r;
  chan_vals_t       held_l;
  chan_vals_t       held_r;
  chan_vals_t       res_l;
  chan_vals_t       res_r;
  logic             res_cal;
  logic             res_just;

  tcbc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Pipeline flow control.
  assign free3 = !ovalid || limits.ready;
  assign mv3   = v3 && free3;
  assign free2 = !v3 || free3;
  assign mv2   = v2 && free2;
  assign free1 = !v2 || free2;
  assign mv1   = v1 && free1;
  assign samples.ready = !v1 || free1;
  assign acc   = samples.valid && samples.ready;

  assign load.s1 = acc;
  assign load.s2 = mv1;
  assign load.s3 = mv2;

  // Sample screening and per-channel decisions at acceptance.
  assign lsamp  = SUM_W'(samples.left_range[RANGE_BITS-1:0]);
  assign rsamp  = SUM_W'(samples.right_range[RANGE_BITS-1:0]);
  assign l_ok   = (lsamp != INVALID_A) && (lsamp != INVALID_B);
  assign r_ok   = (rsamp != INVALID_A) && (rsamp != INVALID_B);
  assign l_full = (left_count == CNT_W'(SAMPLE_COUNT));
  assign r_full = (right_count == CNT_W'(SAMPLE_COUNT));

  always_comb begin
    flags_next.left_rdy   = !done_flag && l_ok && l_full;
    flags_next.right_rdy  = !done_flag && r_ok && r_full;
    flags_next.just       = flags_next.left_rdy && flags_next.right_rdy;
    flags_next.calibrated = done_flag || flags_next.just;
  end

  // Accumulation state.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_sum    <= '0;
      right_sum   <= '0;
      left_count  <= '0;
      right_count <= '0;
      done_flag   <= 1'b0;
    end else if (acc) begin
      if (!done_flag && l_ok && !l_full) begin
        left_sum   <= left_sum + lsamp;
        left_count <= left_count + CNT_W'(1);
      end
      if (!done_flag && r_ok && !r_full) begin
        right_sum   <= right_sum + rsamp;
        right_count <= right_count + CNT_W'(1);
      end
      done_flag <= flags_next.calibrated;
    end
  end

  // Stage valids.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      v2     <= 1'b0;
      v3     <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      v1     <= acc || (v1 && !mv1);
      v2     <= mv1 || (v2 && !mv2);
      v3     <= mv2 || (v3 && !mv3);
      ovalid <= mv3 || (ovalid && !limits.ready);
    end
  end

  // Request flags travel with the datapath stages.
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_fl <= flags_next;
    end
    if (mv1) begin
      s2_fl <= s1_fl;
    end
    if (mv2) begin
      s3_fl <= s2_fl;
    end
  end

  tcbc_chan #(.SAMPLE_COUNT(SAMPLE_COUNT)) u_chan_l (
    .clk  (clk),
    .load (load),
    .sum  (left_sum),
    .cfg  (cfg),
    .vals (vals_l)
  );

  tcbc_chan #(.SAMPLE_COUNT(SAMPLE_COUNT)) u_chan_r (
    .clk  (clk),
    .load (load),
    .sum  (right_sum),
    .cfg  (cfg),
    .vals (vals_r)
  );

  // Held values update in request order as results leave the last stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_l <= '0;
      held_r <= '0;
    end else if (mv3) begin
      if (s3_fl.left_rdy) begin
        held_l <= vals_l;
      end
      if (s3_fl.right_rdy) begin
        held_r <= vals_r;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (mv3) begin
      res_cal  <= s3_fl.calibrated;
      res_just <= s3_fl.just;
      res_l    <= s3_fl.left_rdy ? vals_l : held_l;
      res_r    <= s3_fl.right_rdy ? vals_r : held_r;
    end
  end

  assign limits.valid                    = ovalid;
  assign limits.calibrated               = res_cal;
  assign limits.just_completed           = res_just;
  assign limits.left_baseline            = res_l.baseline;
  assign limits.right_baseline           = res_r.baseline;
  assign limits.left_cliff_threshold     = res_l.cliff;
  assign limits.right_cliff_threshold    = res_r.cliff;
  assign limits.left_obstacle_threshold  = res_l.obstacle;
  assign limits.right_obstacle_threshold = res_r.obstacle;
  assign limits.left_knoll_threshold     = res_l.knoll;
  assign limits.right_knoll_threshold    = res_r.knoll;

endmodule

// ===== rtl/tcbc_checker.sv =====
`include "tof_cliff_baseline_calibrator_macros.svh"

module tcbc_checker import tcbc_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_ready,
  input logic             calibrated,
  input logic             just_completed,
  input logic [LIM_W-1:0] left_baseline,
  input logic [LIM_W-1:0] right_baseline
);

  // No result is presented right after reset.
  `TCBC_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !out_valid, "result valid after reset")

  // A stalled result keeps its contents.
  `TCBC_ASSERT(a_hold, clk, rst, (out_valid && !out_ready) |=> (out_valid && $stable(calibrated) && $stable(just_completed) && $stable(left_baseline) && $stable(right_baseline)), "stalled result changed")

  // Calibration is sticky and completes only once.
  `TCBC_ASSERT(a_sticky, clk, rst, (out_valid && out_ready && calibrated) |=> !(out_valid && (!calibrated || just_completed)), "calibration not sticky")

  // After completion the reported baselines are frozen.
  `TCBC_ASSERT(a_frozen, clk, rst, (out_valid && out_ready && calibrated) |=> (!out_valid || (left_baseline == $past(left_baseline) && right_baseline == $past(right_baseline))), "baseline moved after calibration")

endmodule

bind tof_cliff_baseline_calibrator tcbc_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (limits.valid),
  .out_ready      (limits.ready),
  .calibrated     (limits.calibrated),
  .just_completed (limits.just_completed),
  .left_baseline  (limits.left_baseline),
  .right_baseline (limits.right_baseline)
);
